/* rtl/fqr_pkg.sv */
// fqr_pkg: shared types and constants for the tag queue with keyed removal
// no dependencies; used by the channel interfaces and the top level

package fqr_pkg;

  localparam int TAG_W = 16;
  localparam int OCC_W = 5;

  // command codes carried by an input transaction
  typedef enum logic [1:0] {
    CMD_ENQ    = 2'd0,
    CMD_DEQ    = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

endpackage

/* rtl/fqr_in_if.sv */
// fqr_in_if: command channel (valid/ready plus command and tag)
// depends on fqr_pkg

interface fqr_in_if;
  logic                  valid;
  logic                  ready;
  fqr_pkg::cmd_t         command;
  logic [fqr_pkg::TAG_W-1:0] process_tag;

  modport source (output valid, output command, output process_tag, input ready);
  modport sink   (input valid, input command, input process_tag, output ready);
endinterface

/* rtl/fqr_out_if.sv */
// fqr_out_if: result channel (valid/ready plus tag, status and fill level)
// depends on fqr_pkg

interface fqr_out_if;
  logic                      valid;
  logic                      ready;
  logic [fqr_pkg::TAG_W-1:0] tag_out;
  fqr_pkg::status_t          status;
  logic                      now_empty;
  logic [fqr_pkg::OCC_W-1:0] occupancy;

  modport source (output valid, output tag_out, output status, output now_empty,
                  output occupancy, input ready);
  modport sink   (input valid, input tag_out, input status, input now_empty,
                  input occupancy, output ready);
endinterface

/* rtl/fifo_queue_with_remove_by_key.sv */
// fifo_queue_with_remove_by_key: ordered tag queue in a ring-buffer RAM
// per transaction: enqueue, unused command 3, and dequeue or remove on an empty
// queue go straight to the result; dequeue reads the head; remove does one RAM read
// per entry searched, then one read and one write per entry behind the match
// one transaction at a time; a result waiting in the result register adds its wait
// reset: synchronous active-low rst_n empties the queue; RAM contents not cleared

module fifo_queue_with_remove_by_key #(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  fqr_in_if.sink    in_ch,
  fqr_out_if.source out_ch
);

  import fqr_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DEQ_RD   = 7'b0000010,
    S_SRCH_RD  = 7'b0000100,
    S_SRCH_CMP = 7'b0001000,
    S_SHIFT_RD = 7'b0010000,
    S_SHIFT_WR = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [TAG_W-1:0] key_r, key_nxt;
  logic [TAG_W-1:0] res_tag_r, res_tag_nxt;
  status_t          res_status_r, res_status_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [TAG_W-1:0] out_tag_r;
  status_t          out_status_r;
  logic             out_empty_r;
  logic [OCC_W-1:0] out_occ_r;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [TAG_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [TAG_W-1:0] ram_rdata;

  logic             in_fire;
  logic             out_load;
  logic [CW+OCC_W-1:0] occ_ext;

  // ring address: head plus offset, folded once
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  fqr_ram #(
    .WIDTH (TAG_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign occ_ext     = (CW + OCC_W)'(count_r);

  // sequencer: one RAM access per cycle for search and gap closing
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    key_nxt        = key_r;
    res_tag_nxt    = res_tag_r;
    res_status_nxt = res_status_r;
    ram_we         = 1'b0;
    ram_waddr      = wrap_add(head_r, count_r);
    ram_wdata      = in_ch.process_tag;
    ram_raddr      = head_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          key_nxt        = in_ch.process_tag;
          res_tag_nxt    = '0;
          res_status_nxt = ST_OK;
          idx_nxt        = '0;
          state_nxt      = S_DONE;
          case (in_ch.command)
            CMD_ENQ: begin
              if (count_r == CW'(DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_DEQ: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_DEQ_RD;
              end
            end
            CMD_REMOVE: begin
              if (count_r == '0) begin
                res_status_nxt = ST_NOT_FOUND;
              end else begin
                state_nxt = S_SRCH_RD;
              end
            end
            default: begin
              res_status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_DEQ_RD: begin
        res_tag_nxt = ram_rdata;
        head_nxt    = wrap_add(head_r, CW'(1));
        count_nxt   = count_r - CW'(1);
        state_nxt   = S_DONE;
      end
      S_SRCH_RD: begin
        ram_raddr = wrap_add(head_r, idx_r);
        state_nxt = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (ram_rdata == key_r) begin
          if ((idx_r + CW'(1)) == count_r) begin
            count_nxt = count_r - CW'(1);
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SHIFT_RD;
          end
        end else if ((idx_r + CW'(1)) == count_r) begin
          res_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_SRCH_RD;
        end
      end
      S_SHIFT_RD: begin
        ram_raddr = wrap_add(head_r, idx_r + CW'(1));
        state_nxt = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = wrap_add(head_r, idx_r);
        ram_wdata = ram_rdata;
        idx_nxt   = idx_r + CW'(1);
        if ((idx_r + CW'(2)) == count_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SHIFT_RD;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output valid tracking
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    res_tag_r    <= res_tag_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_tag_r    <= res_tag_r;
      out_status_r <= res_status_r;
      out_empty_r  <= (count_r == '0);
      out_occ_r    <= occ_ext[OCC_W-1:0];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.tag_out   = out_tag_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.now_empty = out_empty_r;
  assign out_ch.occupancy = out_occ_r;

endmodule

/* rtl/fqr_ram.sv */
// fqr_ram: generic single-write, single-read RAM with registered read data
// no dependencies

module fqr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* verif/fifo_queue_with_remove_by_key_tb.sv */
// fifo_queue_with_remove_by_key_tb: drives commands into the tag queue and
// compares every result against a behavioral queue model
// depends on fqr_pkg, fqr_in_if, fqr_out_if and the fifo_queue_with_remove_by_key top
`timescale 1ns / 1ps

module fifo_queue_with_remove_by_key_tb;
  import fqr_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_CYCLES = 50;
  localparam int RANDOM_PER_PHASE = 150;

  typedef struct packed {
    logic [TAG_W-1:0] tag_out;
    status_t          status;
    logic             now_empty;
    logic [OCC_W-1:0] occupancy;
  } queue_result_t;

  // queue model and store of pending results
  class tag_queue_scoreboard;
    logic [TAG_W-1:0] held_tags[$];
    queue_result_t    pending_results[$];
    int               mismatches = 0;

    function void note_command(logic [1:0] command, logic [TAG_W-1:0] tag);
      queue_result_t res;
      int idx;
      res.tag_out = '0;
      res.status  = ST_OK;
      case (command)
        CMD_ENQ: begin
          if (held_tags.size() >= QUEUE_DEPTH) res.status = ST_FULL;
          else held_tags.push_back(tag);
        end
        CMD_DEQ: begin
          if (held_tags.size() == 0) res.status = ST_EMPTY;
          else res.tag_out = held_tags.pop_front();
        end
        CMD_REMOVE: begin
          // first match from the head goes, the rest keep their order
          res.status = ST_NOT_FOUND;
          idx = -1;
          for (int i = 0; i < held_tags.size(); i++) begin
            if (idx < 0 && held_tags[i] == tag) idx = i;
          end
          if (idx >= 0) begin
            held_tags.delete(idx);
            res.status = ST_OK;
          end
        end
        default: ;
      endcase
      res.now_empty = (held_tags.size() == 0);
      res.occupancy = OCC_W'(held_tags.size());
      pending_results.push_back(res);
    endfunction

    function void check_result(queue_result_t seen);
      queue_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result tag=%h status=%0d empty=%b occ=%0d", $realtime,
                   seen.tag_out, seen.status, seen.now_empty, seen.occupancy);
        return;
      end
      want = pending_results.pop_front();
      if (seen !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp tag=%h status=%0d empty=%b occ=%0d,",
                   $realtime, want.tag_out, want.status, want.now_empty, want.occupancy,
                   " got tag=%h status=%0d empty=%b occ=%0d",
                   seen.tag_out, seen.status, seen.now_empty, seen.occupancy);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  fqr_in_if  in_ch();
  fqr_out_if out_ch();

  fifo_queue_with_remove_by_key #(.DEPTH(QUEUE_DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tag_queue_scoreboard sb = new;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_requests;
  int holds_started = 0;
  int hold_left = 0;

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // result side: check each transaction, then pick next ready
  always @(posedge clk) begin
    queue_result_t seen;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.tag_out   = out_ch.tag_out;
      seen.status    = out_ch.status;
      seen.now_empty = out_ch.now_empty;
      seen.occupancy = out_ch.occupancy;
      sb.check_result(seen);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (hold_requests != holds_started) begin
      // long hold-off so results back up and the block stalls its input
      holds_started++;
      hold_left = HOLD_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // offer one command and wait for its transaction
  task automatic send_command(input logic [1:0] command, input logic [TAG_W-1:0] tag);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd_t'(command);
    in_ch.process_tag <= tag;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_command(command, tag);
  endtask

  // tags mostly from the queue or a small pool so removes hit and repeat
  function automatic logic [TAG_W-1:0] pick_tag();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40 && sb.held_tags.size() > 0)
      return sb.held_tags[$urandom_range(sb.held_tags.size() - 1)];
    else if (roll < 70)
      return TAG_W'($urandom_range(7));
    else
      return TAG_W'($urandom);
  endfunction

  // random traffic alternating between fill and drain bias
  task automatic run_random(input int count);
    bit filling;
    int roll;
    logic [1:0] command;
    filling = 1'b1;
    for (int k = 0; k < count; k++) begin
      if (k % 30 == 29) filling = ~filling;
      roll = $urandom_range(99);
      if (filling)
        command = (roll < 60) ? CMD_ENQ : (roll < 75) ? CMD_DEQ :
                  (roll < 96) ? CMD_REMOVE : CMD_UNUSED;
      else
        command = (roll < 20) ? CMD_ENQ : (roll < 58) ? CMD_DEQ :
                  (roll < 96) ? CMD_REMOVE : CMD_UNUSED;
      send_command(command, pick_tag());
    end
  endtask

  // stimulus
  initial begin
    logic [TAG_W-1:0] tag;
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_ENQ;
    in_ch.process_tag = '0;
    hold_requests     = 0;
    send_idle_pct     = 23;
    recv_idle_pct     = 64;
    rst_n             = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty-queue cases, fill to full, removes at head, middle and tail, and a miss
    send_command(CMD_DEQ, 16'h1234);
    send_command(CMD_REMOVE, 16'h0001);
    send_command(CMD_UNUSED, 16'hFFFF);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      tag = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF :
            (i == 3 || i == 9) ? 16'h5A5A : 16'h1000 + TAG_W'(i);
      send_command(CMD_ENQ, tag);
    end
    send_command(CMD_ENQ, 16'h7777);
    send_command(CMD_REMOVE, 16'h5A5A);
    send_command(CMD_REMOVE, 16'h100F);
    send_command(CMD_REMOVE, 16'hFFFF);
    send_command(CMD_REMOVE, 16'hBEEF);
    send_command(CMD_REMOVE, 16'h0000);
    send_command(CMD_DEQ, 16'hFFFF);
    send_command(CMD_UNUSED, 16'hFFFF);

    // random, sender idles less than receiver; one long receiver hold-off
    hold_requests++;
    for (int i = 0; i < 20; i++) send_command(CMD_ENQ, TAG_W'($urandom));
    run_random(RANDOM_PER_PHASE - 20);

    // random, roles swapped
    send_idle_pct = 64;
    recv_idle_pct = 23;
    run_random(RANDOM_PER_PHASE);

    // random, no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(RANDOM_PER_PHASE);
    in_ch.valid <= 1'b0;

    // let outstanding results arrive, then watch for extras
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
